// ===== hdl/mtg_pkg.sv =====
// shared constants, command/status types and tempering function for the mt19937 generator
package mtg_pkg;

  localparam int unsigned STATE_WORDS   = 624;
  localparam int unsigned MIDDLE_OFFSET = 397;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned COUNT_W       = 7;
  localparam int unsigned WORD_W        = 32;

  localparam logic [COUNT_W-1:0] MAX_WORDS   = COUNT_W'(64);
  localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0]   MID_OFS     = IDX_W'(MIDDLE_OFFSET);
  localparam logic [IDX_W-1:0]   WRAP_WORDS  = IDX_W'(STATE_WORDS);
  localparam logic [WORD_W-1:0]  SEED_RESET  = 32'd5489;
  localparam logic [WORD_W-1:0]  SEED_MULT   = 32'd1812433253;
  localparam int unsigned        SEED_SHIFT  = 30;
  localparam logic [WORD_W-1:0]  TWIST_XOR   = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0]  TEMPER_B    = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0]  TEMPER_C    = 32'hEFC6_0000;

  // controller to datapath
  typedef struct packed {
    logic             seed_en;   // write one seeding entry
    logic [IDX_W-1:0] seed_idx;
    logic             rd_en;     // fetch x[p+1] and x[p+397]
    logic [IDX_W-1:0] rd_addr_next;
    logic [IDX_W-1:0] rd_addr_mid;
    logic             twist_en;  // regenerate x[p] and present one item
    logic [IDX_W-1:0] twist_addr;
    logic             last;
  } mtg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } mtg_sts_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mtg_ctrl.sv =====
// controller state machine: seeding sweep, per-word read and twist sequencing
module mtg_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_reseed_i,
  input  logic [mtg_pkg::COUNT_W-1:0]   in_count_i,
  input  mtg_pkg::mtg_sts_t             sts_i,
  output mtg_pkg::mtg_cmd_t             cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_READ,
    ST_TWIST
  } state_e;

  state_e                        state_q;
  logic                          seeded_q;
  logic [mtg_pkg::IDX_W-1:0]     pos_q;
  logic [mtg_pkg::IDX_W-1:0]     idx_q;
  logic [mtg_pkg::COUNT_W-1:0]   rem_q;

  logic                          in_acc;
  logic [mtg_pkg::COUNT_W-1:0]   count_sat;
  logic [mtg_pkg::IDX_W-1:0]     pos_next;
  logic [mtg_pkg::IDX_W:0]       mid_sum;
  logic [mtg_pkg::IDX_W-1:0]     pos_mid;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign count_sat  = (in_count_i > mtg_pkg::MAX_WORDS) ? mtg_pkg::MAX_WORDS : in_count_i;

  assign pos_next = (pos_q == mtg_pkg::LAST_IDX) ? '0 : pos_q + 1'b1;
  assign mid_sum  = {1'b0, pos_q} + {1'b0, mtg_pkg::MID_OFS};
  // wrap modulo the state length, the sum stays below twice of it
  assign pos_mid  = (mid_sum >= {1'b0, mtg_pkg::WRAP_WORDS})
                    ? mtg_pkg::IDX_W'(mid_sum - {1'b0, mtg_pkg::WRAP_WORDS})
                    : mid_sum[mtg_pkg::IDX_W-1:0];

  always_comb begin
    cmd_o              = '0;
    cmd_o.seed_en      = (state_q == ST_SEED);
    cmd_o.seed_idx     = idx_q;
    cmd_o.rd_en        = (state_q == ST_READ);
    cmd_o.rd_addr_next = pos_next;
    cmd_o.rd_addr_mid  = pos_mid;
    cmd_o.twist_en     = (state_q == ST_TWIST) && sts_i.out_free;
    cmd_o.twist_addr   = pos_q;
    cmd_o.last         = (rem_q == mtg_pkg::COUNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seeded_q <= 1'b0;
      pos_q    <= '0;
      idx_q    <= '0;
      rem_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            rem_q <= count_sat;
            if (in_reseed_i || !seeded_q) begin
              state_q  <= ST_SEED;
              seeded_q <= 1'b1;
              pos_q    <= '0;
              idx_q    <= '0;
            end else if (count_sat != '0) begin
              state_q <= ST_READ;
            end
          end
        end
        ST_SEED: begin
          if (idx_q == mtg_pkg::LAST_IDX) begin
            idx_q   <= '0;
            state_q <= (rem_q != '0) ? ST_READ : ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_READ: begin
          state_q <= ST_TWIST;
        end
        ST_TWIST: begin
          if (sts_i.out_free) begin
            pos_q   <= pos_next;
            rem_q   <= rem_q - 1'b1;
            state_q <= (rem_q == mtg_pkg::COUNT_W'(1)) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mtg_pkg::LAST_IDX)
    else $error("position out of range");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= mtg_pkg::MAX_WORDS)
    else $error("remaining count above limit");

  a_first_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !seeded_q) |=> (state_q == ST_SEED && pos_q == '0))
    else $error("unseeded request did not seed");

  a_twist_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.twist_en |-> (sts_i.out_free && rem_q != '0))
    else $error("twist without room or without pending words");

endmodule

// ===== hdl/mtg_dp.sv =====
// datapath: state memory, seeding multiplier, twist and temper, output register
module mtg_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mtg_pkg::WORD_W-1:0]   cfg_wdata_i,
  input  mtg_pkg::mtg_cmd_t            cmd_i,
  output mtg_pkg::mtg_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mtg_pkg::WORD_W-1:0]   out_word_o,
  output logic                         out_last_o
);

  logic [mtg_pkg::WORD_W-1:0] mem_q [mtg_pkg::STATE_WORDS];

  logic [mtg_pkg::WORD_W-1:0] seed_q;
  logic [mtg_pkg::WORD_W-1:0] prev_q;
  logic [mtg_pkg::WORD_W-1:0] cur_q;     // always x[position]
  logic [mtg_pkg::WORD_W-1:0] rd_next_q;
  logic [mtg_pkg::WORD_W-1:0] rd_mid_q;
  logic                       out_valid_q;
  logic [mtg_pkg::WORD_W-1:0] out_word_q;
  logic                       out_last_q;

  logic [mtg_pkg::WORD_W-1:0] mix;
  logic [mtg_pkg::WORD_W-1:0] seed_word;
  logic [mtg_pkg::WORD_W-1:0] twist_y;
  logic [mtg_pkg::WORD_W-1:0] twist_word;
  logic                       we;
  logic [mtg_pkg::IDX_W-1:0]  wr_addr;
  logic [mtg_pkg::WORD_W-1:0] wr_data;

  assign mix       = prev_q ^ (prev_q >> mtg_pkg::SEED_SHIFT);
  assign seed_word = (cmd_i.seed_idx == '0) ? seed_q
                     : mtg_pkg::WORD_W'(mtg_pkg::SEED_MULT * mix)
                       + {{(mtg_pkg::WORD_W-mtg_pkg::IDX_W){1'b0}}, cmd_i.seed_idx};

  assign twist_y    = {cur_q[mtg_pkg::WORD_W-1], rd_next_q[mtg_pkg::WORD_W-2:0]};
  assign twist_word = rd_mid_q ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TWIST_XOR : '0);

  assign we      = cmd_i.seed_en || cmd_i.twist_en;
  assign wr_addr = cmd_i.seed_en ? cmd_i.seed_idx : cmd_i.twist_addr;
  assign wr_data = cmd_i.seed_en ? seed_word : twist_word;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_next_q <= mem_q[cmd_i.rd_addr_next];
      rd_mid_q  <= mem_q[cmd_i.rd_addr_mid];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_en) begin
      prev_q <= seed_word;
    end
    if (cmd_i.seed_en && cmd_i.seed_idx == '0) begin
      cur_q <= seed_q;
    end else if (cmd_i.twist_en) begin
      cur_q <= rd_next_q;
    end
    if (cmd_i.twist_en) begin
      out_word_q <= mtg_pkg::temper(twist_word);
      out_last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= mtg_pkg::SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.twist_en) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// top level of the mt19937 generator: controller plus datapath
// Usage:
// - s_axis carries one request item: tdata bit 0 = reseed, bits 7:1 = count.
//   count above 64 is taken as 64; a count of zero emits nothing.
// - m_axis returns count tempered 32-bit words, tlast high on the final one.
// - cfg_we_i / cfg_wdata_i load the seed register (reset value 5489); write
//   it only while no request is in flight.
// - A request with reseed set, or the first request after reset, first
//   sweeps the 624-word state memory from the seed, one entry per cycle,
//   before the first word is made.
// - Each word then goes through a read step, fetching x[p+1] and x[p+397]
//   from the two-read-port state memory, and a twist step that writes back
//   x[p] and tempers the new word into the output register.
// - s_axis_tready is high only between requests.
// - When the receiver stalls, the word waits in the output register and the
//   sequencer holds until it is taken.
// - Reset clears the position and the seeded flag; the state memory keeps
//   no defined value until it is seeded.
module mersenne_twister_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] reseed, [7:1] count
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] random_word
  output logic        m_axis_tlast
);

  mtg_pkg::mtg_cmd_t cmd;
  mtg_pkg::mtg_sts_t sts;

  mtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_reseed_i (s_axis_tdata[0]),
    .in_count_i  (s_axis_tdata[7:1]),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mtg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
